// File: rtl/tch_pkg.sv
// package for the tilt compensated height integrator
// constants, arctangent table and field widths; no dependencies
`default_nettype none
package tch_pkg;
    localparam int CordicIterations = 16;
    localparam int AtanEntries = 24;
    localparam int IterCount = (CordicIterations < AtanEntries) ? CordicIterations : AtanEntries;
    localparam int IterWidth = $clog2(AtanEntries + 1);
    localparam logic signed [33:0] CordicGainInv = 34'sd652032874;
    localparam logic [15:0] StepReset = 16'd328;
    localparam logic [19:0] GravityReset = 20'd642690;
    localparam logic [0:0] CfgStepIdx = 1'b0;
    localparam logic [0:0] CfgGravityIdx = 1'b1;

    function automatic logic [29:0] atan_lookup(input logic [IterWidth-1:0] idx);
        logic [29:0] r;
        begin
            unique case (idx)
                5'd0: r = 30'd536870912;
                5'd1: r = 30'd316933406;
                5'd2: r = 30'd167458907;
                5'd3: r = 30'd85004756;
                5'd4: r = 30'd42667331;
                5'd5: r = 30'd21354465;
                5'd6: r = 30'd10679838;
                5'd7: r = 30'd5340245;
                5'd8: r = 30'd2670163;
                5'd9: r = 30'd1335087;
                5'd10: r = 30'd667544;
                5'd11: r = 30'd333772;
                5'd12: r = 30'd166886;
                5'd13: r = 30'd83443;
                5'd14: r = 30'd41722;
                5'd15: r = 30'd20861;
                5'd16: r = 30'd10430;
                5'd17: r = 30'd5215;
                5'd18: r = 30'd2608;
                5'd19: r = 30'd1304;
                5'd20: r = 30'd652;
                5'd21: r = 30'd326;
                5'd22: r = 30'd163;
                5'd23: r = 30'd81;
                default: r = 30'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        end
    endfunction
endpackage
`default_nettype wire

// File: rtl/tch_cordic.sv
// iterative rotation cordic, one micro-rotation per cycle
// depends on tch_pkg
`default_nettype none
module tch_cordic
    import tch_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [15:0] angle,
    output logic                    done,
    output logic signed [33:0]      sin_out,
    output logic signed [33:0]      cos_out
);
    logic signed [33:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic neg_reg, busy_reg;
    logic [IterWidth-1:0] i_reg;
    logic signed [33:0] z0;
    logic signed [33:0] xs, ys, at;

    always_comb begin
        z0 = {{2{angle[15]}}, angle, 16'd0};
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        at = {4'd0, atan_lookup(i_reg)};
    end

    assign sin_out = neg_reg ? -y_reg : y_reg;
    assign cos_out = neg_reg ? -x_reg : x_reg;

    always_ff @(posedge aclk) begin
        done <= 1'b0;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            i_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            i_reg <= '0;
            x_reg <= CordicGainInv;
            y_reg <= '0;
            if (z0 > 34'sd1073741824) begin
                z_reg <= z0 - 34'sd2147483648;
                neg_reg <= 1'b1;
            end else if (z0 < -34'sd1073741824) begin
                z_reg <= z0 + 34'sd2147483648;
                neg_reg <= 1'b1;
            end else begin
                z_reg <= z0;
                neg_reg <= 1'b0;
            end
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
            i_reg <= i_reg + 1'b1;
            if (i_reg == IterWidth'(IterCount - 1)) begin
                busy_reg <= 1'b0;
                done <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/tilt_compensated_height_integrator.sv
// top level of the tilt compensated height integrator
// sequences cordic, a shared 34x34 multiply and the two trapezoid integrators
// depends on tch_pkg, tch_cordic
//
// usage: one input beat on s_axis carries a sample (s_axis_tuser = 0) or a
// reinit (s_axis_tuser = 1). every beat yields exactly one m_axis beat that
// holds the height estimate in q16.16 metres.
// a sample runs two cordic passes (load plus 16 rotations each) on one shared
// rotator, then multiply, integrate and output in states S_M1 to S_M6, S_V,
// S_H and S_OUT on one shared multiplier; S_OUT sets m_axis_tvalid. a reinit
// goes straight from accept to S_OUT. a new beat is taken only once the block
// is back in S_IDLE and the previous result has left the output register.
// s_axis_tready is high only when the block is idle and the output register is
// empty; while the receiver stalls the result is held in the output register
// and no new beat is taken.
// reset (aresetn low, synchronous) clears velocity, height, previous values
// and restores step_seconds = 328 and gravity = 642690.
// cfg writes (cfg_we, cfg_addr, cfg_wdata) take effect at once; index 0 is
// step_seconds, index 1 gravity, other indexes are ignored.
`default_nettype none
module tilt_compensated_height_integrator
    import tch_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_addr,
    input  wire logic [19:0]  cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // acc_x, acc_y, acc_z, roll_angle, pitch_angle, init_height, init_velocity
    input  wire logic [143:0] s_axis_tdata,
    // action
    input  wire logic [0:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // height
    output logic [31:0]       m_axis_tdata
);
    typedef enum logic [3:0] {
        S_IDLE, S_ROLL, S_PITCH, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
        S_V, S_H, S_OUT
    } state_t;

    state_t state_reg;
    logic [15:0] step_reg;
    logic [19:0] grav_reg;
    logic signed [31:0] vel_reg, hgt_reg, pvel_reg, pacc_reg, acc_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg, pitch_reg;
    logic signed [33:0] sr_reg, cr_reg, sp_reg, cp_reg;
    logic signed [67:0] f_reg;
    logic signed [67:0] prod;
    logic signed [33:0] ma, mb;
    logic cstart, cdone;
    logic signed [15:0] cangle;
    logic signed [33:0] csin, ccos;
    logic signed [63:0] ftrunc;

    tch_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cstart), .angle(cangle),
        .done(cdone), .sin_out(csin), .cos_out(ccos)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !m_axis_tvalid;
    assign cstart = (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0])
                    || (state_reg == S_ROLL && cdone);
    assign cangle = (state_reg == S_IDLE) ? $signed(s_axis_tdata[63:48]) : pitch_reg;
    assign m_axis_tdata = hgt_reg;

    always_comb begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            S_M1: begin ma = cp_reg; mb = sr_reg; end
            S_M2: begin ma = cp_reg; mb = cr_reg; end
            S_M3: begin ma = -34'(ax_reg); mb = sp_reg; end
            S_M4: begin ma = 34'(ay_reg); mb = sr_reg; end
            S_M5: begin ma = 34'(az_reg); mb = cr_reg; end
            S_M6: begin ma = 34'(f_reg >>> 26); mb = $signed({14'd0, grav_reg}); end
            S_V: begin ma = 34'(acc_reg) + 34'(pacc_reg); mb = $signed({18'd0, step_reg}); end
            S_H: begin ma = 34'(vel_reg) + 34'(pvel_reg); mb = $signed({18'd0, step_reg}); end
            default: begin ma = '0; mb = '0; end
        endcase
        prod = ma * mb;
        ftrunc = 64'(prod >>> 16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg <= StepReset;
            grav_reg <= GravityReset;
            vel_reg <= '0;
            hgt_reg <= '0;
            pvel_reg <= '0;
            pacc_reg <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == CfgStepIdx) step_reg <= cfg_wdata[15:0];
                else if (cfg_addr == CfgGravityIdx) grav_reg <= cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    if (s_axis_tuser[0]) begin
                        hgt_reg <= $signed(s_axis_tdata[111:80]);
                        vel_reg <= $signed(s_axis_tdata[143:112]);
                        pvel_reg <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        ax_reg <= $signed(s_axis_tdata[15:0]);
                        ay_reg <= $signed(s_axis_tdata[31:16]);
                        az_reg <= $signed(s_axis_tdata[47:32]);
                        pitch_reg <= $signed(s_axis_tdata[79:64]);
                        state_reg <= S_ROLL;
                    end
                end
                S_ROLL: if (cdone) begin
                    sr_reg <= csin;
                    cr_reg <= ccos;
                    state_reg <= S_PITCH;
                end
                S_PITCH: if (cdone) begin
                    sp_reg <= csin;
                    cp_reg <= ccos;
                    state_reg <= S_M1;
                end
                S_M1: begin
                    sr_reg <= 34'(prod >>> 30);
                    state_reg <= S_M2;
                end
                S_M2: begin
                    cr_reg <= 34'(prod >>> 30);
                    state_reg <= S_M3;
                end
                S_M3: begin
                    f_reg <= prod - (68'sd1 <<< 42);
                    state_reg <= S_M4;
                end
                S_M4: begin
                    f_reg <= f_reg + prod;
                    state_reg <= S_M5;
                end
                S_M5: begin
                    f_reg <= f_reg + prod;
                    state_reg <= S_M6;
                end
                S_M6: begin
                    acc_reg <= sat32(ftrunc);
                    state_reg <= S_V;
                end
                S_V: begin
                    vel_reg <= sat32(64'(vel_reg) + 64'(prod >>> 17));
                    pacc_reg <= acc_reg;
                    state_reg <= S_H;
                end
                S_H: begin
                    hgt_reg <= sat32(64'(hgt_reg) + 64'(prod >>> 17));
                    pvel_reg <= vel_reg;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    m_axis_tvalid <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
